// ----- hdl/cq_pkg.sv -----
// Shared constants and types for the circular queue.
`timescale 1ns / 1ps

package cq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_W-1:0] OP_SHOW = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic                     peek;
        logic                     show;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

endpackage

// ----- hdl/cq_front.sv -----
// Front end: accepts transfers, decodes the opcode and holds a two-entry command queue.
`timescale 1ns / 1ps

module cq_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [cq_pkg::OP_W-1:0]                 opcode,
    input  logic signed [cq_pkg::WORD_W-1:0]        value,
    output logic                                    cmd_valid,
    output cq_pkg::cmd_t                            cmd,
    input  logic                                    cmd_pop
);
    import cq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       dec;

    always_comb
    begin
        dec       = '0;
        dec.value = value;
        unique case (opcode)
            OP_ENQ:  dec.enq  = 1'b1;
            OP_DEQ:  dec.deq  = 1'b1;
            OP_PEEK: dec.peek = 1'b1;
            OP_SHOW: dec.show = 1'b1;
            default: dec.show = 1'b1;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- hdl/cq_back.sv -----
// Back end: entry storage, pointers, command execution and the output register.
`timescale 1ns / 1ps

module cq_back #(
    parameter int DEPTH = cq_pkg::DEPTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_valid,
    input  cq_pkg::cmd_t                            cmd,
    output logic                                    cmd_pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [cq_pkg::ST_W-1:0]                 status,
    output logic signed [cq_pkg::WORD_W-1:0]        data,
    output logic                                    last,
    output logic [$clog2(DEPTH+1)-1:0]              fill
);
    import cq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    logic [1:0]        state_reg,  state_next;
    logic [PTR_W-1:0]  head_reg,   head_next;
    logic [PTR_W-1:0]  tail_reg,   tail_next;
    logic [PTR_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   status_reg;
    logic signed [WORD_W-1:0] data_reg;
    logic              last_reg;

    logic              out_free;
    logic              mem_we;
    logic              load;
    logic [ST_W-1:0]   ld_status;
    logic signed [WORD_W-1:0] ld_data;
    logic              ld_last;

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        mem_we      = 1'b0;
        cmd_pop     = 1'b0;
        load        = 1'b0;
        ld_status   = ST_OK;
        ld_data     = '0;
        ld_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.enq)
                    begin
                        load = 1'b1;
                        if (fill_reg == FULL)
                        begin
                            ld_status = ST_OVER;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            tail_next = nxt(tail_reg);
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        load      = 1'b1;
                        ld_status = ST_EMPTY;
                    end
                    else
                    begin
                        cursor_next = head_reg;
                        state_next  = S_WAIT;
                        remain_next = CNT_W'(1);
                        if (cmd.deq)
                        begin
                            fill_next = fill_reg - CNT_W'(1);
                            if (fill_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                head_next = nxt(head_reg);
                            end
                        end
                        else if (cmd.show)
                        begin
                            remain_next = fill_reg;
                        end
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_data = rd_data_reg;
                    ld_last = (remain_reg == CNT_W'(1));
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - CNT_W'(1);
                        cursor_next = nxt(cursor_reg);
                        state_next  = S_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            fill_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= cmd.value;
        end
        rd_data_reg <= mem[cursor_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= ld_status;
            data_reg   <= ld_data;
            last_reg   <= ld_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign fill      = fill_reg;

endmodule

// ----- hdl/circular_queue.sv -----
// Top level of the circular queue: command front end, execution back end, checks.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------
//  in      | input     | in_valid / in_stall   | opcode, value
//  out     | output    | out_valid / out_stall | status, data, last
//
//  Enqueue and any command on an empty queue produce their result directly from
//  the idle state. Dequeue and peek pass through a wait state and a send state;
//  display repeats both per entry, for the registered read of the entry storage.
//  The front holds two decoded commands, so up to two input transfers are accepted
//  while the back end works or the output is stalled.
//  Reset clears pointers and fill count; entry storage is not cleared.
`timescale 1ns / 1ps

module circular_queue #(
    parameter int DEPTH = cq_pkg::DEPTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [cq_pkg::OP_W-1:0]                 opcode,
    input  logic signed [cq_pkg::WORD_W-1:0]        value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [cq_pkg::ST_W-1:0]                 status,
    output logic signed [cq_pkg::WORD_W-1:0]        data,
    output logic                                    last
);
    import cq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    logic [CNT_W-1:0] fill;

    cq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last),
        .fill      (fill)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_over_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVER) |-> last && (data == '0))
        else $error("overflow result malformed");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> last && (data == '0))
        else $error("empty result malformed");

endmodule

// ----- test/tb_circular_queue.sv -----
// Testbench for circular_queue: directed table, then random traffic checked against a queue model.
`timescale 1ns / 1ps

module tb_circular_queue;

    import cq_pkg::*;

    localparam int QD           = DEPTH_DEFAULT;
    localparam int N_RANDOM     = 75;
    localparam int LONG_HOLD    = 60;
    localparam int WD_LIMIT     = 1000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } qresult_t;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] val;
        bit                       typed;
        logic [ST_W-1:0]          st;
        logic signed [WORD_W-1:0] dat;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode    = OP_ENQ;
    logic signed [WORD_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] data;
    logic                     last;

    logic signed [WORD_W-1:0] q_mem [QD];
    int                       q_head;
    int                       q_tail;
    int                       q_fill;

    qresult_t  model_out[$];
    qresult_t  pending[$];
    stim_row_t dir_rows[$];
    qresult_t  want;

    int n_err;
    int burst_left;
    bit gapless;
    bit long_hold_req;
    int idle_cycles;

    circular_queue #(.DEPTH(QD)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic qresult_t mk_result(input logic [ST_W-1:0] st,
                                           input logic signed [WORD_W-1:0] d,
                                           input logic l);
        qresult_t r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        return r;
    endfunction

    function automatic void predict_queue_op(input logic [OP_W-1:0] op,
                                             input logic signed [WORD_W-1:0] val);
        int idx;
        if (op == OP_ENQ)
        begin
            if (q_fill >= QD)
                model_out.push_back(mk_result(ST_OVER, '0, 1'b1));
            else
            begin
                q_mem[q_tail] = val;
                q_tail = (q_tail + 1) % QD;
                q_fill++;
                model_out.push_back(mk_result(ST_OK, '0, 1'b1));
            end
        end
        else if (q_fill == 0)
            model_out.push_back(mk_result(ST_EMPTY, '0, 1'b1));
        else if (op == OP_DEQ)
        begin
            model_out.push_back(mk_result(ST_OK, q_mem[q_head], 1'b1));
            q_fill--;
            if (q_fill == 0)
            begin
                q_head = 0;
                q_tail = 0;
            end
            else
                q_head = (q_head + 1) % QD;
        end
        else if (op == OP_PEEK)
            model_out.push_back(mk_result(ST_OK, q_mem[q_head], 1'b1));
        else
        begin
            idx = q_head;
            for (int k = 0; k < q_fill; k++)
            begin
                model_out.push_back(mk_result(ST_OK, q_mem[idx], k == q_fill - 1));
                idx = (idx + 1) % QD;
            end
        end
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op,
                                    input logic signed [WORD_W-1:0] val,
                                    input bit typed,
                                    input logic [ST_W-1:0] st,
                                    input logic signed [WORD_W-1:0] dat);
        stim_row_t r;
        r.op    = op;
        r.val   = val;
        r.typed = typed;
        r.st    = st;
        r.dat   = dat;
        dir_rows.push_back(r);
    endfunction

    // one transfer on the input side, then burst/gap pacing unless gapless is set
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [WORD_W-1:0] val,
                             input bit typed,
                             input logic [ST_W-1:0] t_st,
                             input logic signed [WORD_W-1:0] t_dat);
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        model_out.delete();
        predict_queue_op(op, val);
        if (typed)
            pending.push_back(mk_result(t_st, t_dat, 1'b1));
        else
            foreach (model_out[i])
                pending.push_back(model_out[i]);
        if (gapless)
            return;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    initial
    begin : rx_stall
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 40);
            repeat (span)
            begin
                @(posedge clk);
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: status %0d data %0d last %0d",
                       status, data, last);
                n_err++;
            end
            else
            begin
                want = pending.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_err++;
                end
                if (data !== want.data)
                begin
                    $error("data: expected %0d, got %0d", want.data, data);
                    n_err++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    n_err++;
                end
            end
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int                       r;
        bit                       fill_bias;
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] val;

        n_err      = 0;
        burst_left = 0;
        gapless    = 1'b0;
        q_head     = 0;
        q_tail     = 0;
        q_fill     = 0;
        fill_bias  = 1'b1;

        // empty queue
        add_row(OP_PEEK, 32'sd0,          1, ST_EMPTY, 32'sd0);
        add_row(OP_DEQ,  32'sh7FFFFFFF,   1, ST_EMPTY, 32'sd0);
        add_row(OP_SHOW, 32'sh80000000,   1, ST_EMPTY, 32'sd0);
        // fill to the top
        add_row(OP_ENQ,  32'sh7FFFFFFF,   1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sh80000000,   1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sd0,          1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  -32'sd1,         1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sd1,          1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sh55555555,   1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'shAAAAAAAA,   1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sd12345,      1, ST_OK,    32'sd0);
        add_row(OP_ENQ,  32'sd42,         1, ST_OVER,  32'sd0);
        add_row(OP_PEEK, 32'sd0,          1, ST_OK,    32'sh7FFFFFFF);
        add_row(OP_SHOW, 32'sd0,          0, ST_OK,    32'sd0);
        add_row(OP_DEQ,  32'sd0,          1, ST_OK,    32'sh7FFFFFFF);
        // tail wraps
        add_row(OP_ENQ,  32'sh13579BDF,   1, ST_OK,    32'sd0);
        add_row(OP_SHOW, 32'sd0,          0, ST_OK,    32'sd0);
        // drain to empty, pointers return to zero
        repeat (QD) add_row(OP_DEQ, 32'sd0, 0, ST_OK, 32'sd0);
        add_row(OP_DEQ,  32'sd0,          1, ST_EMPTY, 32'sd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                      dir_rows[i].st, dir_rows[i].dat);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 25 == 0)
                fill_bias = $urandom_range(0, 1);
            if (n == 30)
            begin
                // receiver holds off while input keeps coming
                long_hold_req = 1'b1;
                gapless       = 1'b1;
                fill_bias     = 1'b1;
            end
            if (n == 50)
                gapless = 1'b0;
            if (n == 70)
            begin
                if (in_valid)
                    in_valid <= 1'b0;
                @(posedge clk);
                while (pending.size() != 0) @(posedge clk);
            end

            r = $urandom_range(0, 99);
            if (fill_bias)
                op = (r < 60) ? OP_ENQ : (r < 75) ? OP_DEQ : (r < 88) ? OP_PEEK : OP_SHOW;
            else
                op = (r < 25) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 80) ? OP_PEEK : OP_SHOW;
            case ($urandom_range(0, 7))
                0:       val = 32'sh7FFFFFFF;
                1:       val = 32'sh80000000;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            send_item(op, val, 0, ST_OK, 32'sd0);
        end

        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cq_pkg.sv
hdl/cq_front.sv
hdl/cq_back.sv
hdl/circular_queue.sv
test/tb_circular_queue.sv
